@@ hdl/fcgi_rhp_pkg.sv @@
// ----------------------------------------------------------------------------
// fcgi_rhp_pkg: FastCGI response header parser package
// Event codes, record types, parser states and event set helper.
// ----------------------------------------------------------------------------
package fcgi_rhp_pkg;

    // event kinds
    localparam logic [2:0] KIND_NAME        = 3'd0;
    localparam logic [2:0] KIND_VALUE       = 3'd1;
    localparam logic [2:0] KIND_LINE_END    = 3'd2;
    localparam logic [2:0] KIND_HEADERS_END = 3'd3;
    localparam logic [2:0] KIND_BODY        = 3'd4;
    localparam logic [2:0] KIND_DONE        = 3'd5;
    localparam logic [2:0] KIND_ABORTED     = 3'd6;

    // record types
    localparam logic [7:0] REC_ABORT  = 8'd2;
    localparam logic [7:0] REC_END    = 8'd3;
    localparam logic [7:0] REC_STDOUT = 8'd6;

    // header byte positions
    localparam logic [2:0] HDR_TYPE    = 3'd1;
    localparam logic [2:0] HDR_LEN_HI  = 3'd4;
    localparam logic [2:0] HDR_LEN_LO  = 3'd5;
    localparam logic [2:0] HDR_PADDING = 3'd6;
    localparam logic [2:0] HDR_LAST    = 3'd7;

    // characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // result queue depth
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_CONTENT = 3'b010,
        PH_PADDING = 3'b100
    } phase_t;

    typedef enum logic [6:0] {
        LS_START    = 7'b0000001,
        LS_NAME     = 7'b0000010,
        LS_SKIP     = 7'b0000100,
        LS_VALUE    = 7'b0001000,
        LS_CR       = 7'b0010000,
        LS_LF       = 7'b0100000,
        LS_BLANK_CR = 7'b1000000
    } line_state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } event_set_t;

    // append one event, at most two per input byte
    function automatic event_set_t add_event(input event_set_t s, input logic [2:0] kind,
                                             input logic [7:0] data);
        event_set_t t;
        t = s;
        if (s.count == 2'd0)
        begin
            t.r0.kind = kind;
            t.r0.data = data;
            t.count   = 2'd1;
        end
        else if (s.count == 2'd1)
        begin
            t.r1.kind = kind;
            t.r1.data = data;
            t.count   = 2'd2;
        end
        return t;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

endpackage

@@ hdl/fastcgi_response_header_parser.sv @@
// ----------------------------------------------------------------------------
// fastcgi_response_header_parser: FastCGI deframer with CGI header parser
// Deframes FastCGI records, parses STDOUT header lines and passes the body.
// ----------------------------------------------------------------------------
// A result enters the result queue when its byte is accepted and is shown
// from the queue head. Throughput: one byte per cycle while s_axis_tready is
//   high; a byte with two events fills two entries of a four-entry queue.
// s_axis_tready is high while the queue holds at most two results.
// Reset: asynchronous, active low; parser returns to awaiting a record header.
module fastcgi_response_header_parser
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] stream_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] event_byte
    output logic [2:0] m_axis_tuser,   // [2:0] event_kind
    output logic       m_axis_tlast    // last_of_run
);

    fcgi_rhp_pkg::phase_t      phase_reg, phase_next;
    fcgi_rhp_pkg::line_state_t line_reg, line_next;
    logic [2:0]  hidx_reg, hidx_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] content_reg, content_next;
    logic [7:0]  pad_reg, pad_next;
    logic        body_reg, body_next;

    fcgi_rhp_pkg::event_set_t ev;
    fcgi_rhp_pkg::result_t    queue_mem [fcgi_rhp_pkg::QUEUE_DEPTH];
    fcgi_rhp_pkg::result_t    head_res;

    logic [fcgi_rhp_pkg::QPTR_W-1:0] head_reg, tail_reg;
    logic [fcgi_rhp_pkg::QPTR_W:0]   count_reg, count_next;
    logic [7:0] b;
    logic       accept, pop;

    assign b             = s_axis_tdata;
    assign s_axis_tready = (count_reg < 3'd3);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != 3'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    // per-byte deframing and header parsing
    always_comb
    begin
        phase_next   = phase_reg;
        line_next    = line_reg;
        hidx_next    = hidx_reg;
        kind_next    = kind_reg;
        len_hi_next  = len_hi_reg;
        content_next = content_reg;
        pad_next     = pad_reg;
        body_next    = body_reg;
        ev           = '0;

        case (phase_reg)
            fcgi_rhp_pkg::PH_CONTENT:
            begin
                content_next = content_reg - 16'd1;
                if (kind_reg == fcgi_rhp_pkg::REC_STDOUT)
                begin
                    if (body_reg)
                    begin
                        // swallow the line feed of a CR LF blank line
                        line_next = fcgi_rhp_pkg::LS_START;
                        if (!(line_reg == fcgi_rhp_pkg::LS_BLANK_CR && b == fcgi_rhp_pkg::CH_LF))
                            ev = fcgi_rhp_pkg::add_event(ev, fcgi_rhp_pkg::KIND_BODY, b);
                    end
                    else
                    begin
                        logic do_start;
                        do_start = 1'b0;
                        case (line_reg)
                            fcgi_rhp_pkg::LS_NAME:
                            begin
                                if (b == fcgi_rhp_pkg::CH_COLON)
                                    line_next = fcgi_rhp_pkg::LS_SKIP;
                                else if (b == fcgi_rhp_pkg::CH_CR)
                                    line_next = fcgi_rhp_pkg::LS_CR;
                                else if (b == fcgi_rhp_pkg::CH_LF)
                                    line_next = fcgi_rhp_pkg::LS_LF;
                                else
                                    ev = fcgi_rhp_pkg::add_event(ev,
                                        fcgi_rhp_pkg::KIND_NAME, b);
                            end
                            fcgi_rhp_pkg::LS_SKIP, fcgi_rhp_pkg::LS_VALUE:
                            begin
                                if (!(line_reg == fcgi_rhp_pkg::LS_SKIP
                                      && fcgi_rhp_pkg::is_blank(b)))
                                begin
                                    if (b == fcgi_rhp_pkg::CH_CR)
                                        line_next = fcgi_rhp_pkg::LS_CR;
                                    else if (b == fcgi_rhp_pkg::CH_LF)
                                        line_next = fcgi_rhp_pkg::LS_LF;
                                    else
                                    begin
                                        ev = fcgi_rhp_pkg::add_event(ev,
                                            fcgi_rhp_pkg::KIND_VALUE, b);
                                        line_next = fcgi_rhp_pkg::LS_VALUE;
                                    end
                                end
                            end
                            fcgi_rhp_pkg::LS_CR, fcgi_rhp_pkg::LS_LF:
                            begin
                                if (line_reg == fcgi_rhp_pkg::LS_CR && b == fcgi_rhp_pkg::CH_LF)
                                    line_next = fcgi_rhp_pkg::LS_LF;
                                else if (fcgi_rhp_pkg::is_blank(b))
                                    line_next = fcgi_rhp_pkg::LS_SKIP;   // folded line
                                else
                                begin
                                    ev = fcgi_rhp_pkg::add_event(ev,
                                        fcgi_rhp_pkg::KIND_LINE_END, 8'h00);
                                    do_start = 1'b1;
                                end
                            end
                            default:
                            begin
                                do_start = 1'b1;
                            end
                        endcase

                        // first byte of a header line
                        if (do_start)
                        begin
                            if (b == fcgi_rhp_pkg::CH_CR || b == fcgi_rhp_pkg::CH_LF)
                            begin
                                ev = fcgi_rhp_pkg::add_event(ev,
                                    fcgi_rhp_pkg::KIND_HEADERS_END, 8'h00);
                                body_next = 1'b1;
                                line_next = (b == fcgi_rhp_pkg::CH_CR)
                                    ? fcgi_rhp_pkg::LS_BLANK_CR : fcgi_rhp_pkg::LS_START;
                            end
                            else if (b == fcgi_rhp_pkg::CH_COLON)
                                line_next = fcgi_rhp_pkg::LS_SKIP;
                            else
                            begin
                                ev = fcgi_rhp_pkg::add_event(ev, fcgi_rhp_pkg::KIND_NAME, b);
                                line_next = fcgi_rhp_pkg::LS_NAME;
                            end
                        end
                    end
                end
                if (content_next == 16'd0)
                begin
                    if (pad_reg != 8'd0)
                        phase_next = fcgi_rhp_pkg::PH_PADDING;
                    else
                        phase_next = fcgi_rhp_pkg::PH_HEADER;  // record end below
                end
            end
            fcgi_rhp_pkg::PH_PADDING:
            begin
                pad_next = pad_reg - 8'd1;
                if (pad_next == 8'd0)
                    phase_next = fcgi_rhp_pkg::PH_HEADER;
            end
            default:
            begin
                phase_next = fcgi_rhp_pkg::PH_HEADER;
                case (hidx_reg)
                    fcgi_rhp_pkg::HDR_TYPE:    kind_next = b;
                    fcgi_rhp_pkg::HDR_LEN_HI:  len_hi_next = b;
                    fcgi_rhp_pkg::HDR_LEN_LO:  content_next = {len_hi_reg, b};
                    fcgi_rhp_pkg::HDR_PADDING: pad_next = b;
                    default:                   ;
                endcase
                hidx_next = hidx_reg + 3'd1;
                if (hidx_reg == fcgi_rhp_pkg::HDR_LAST)
                begin
                    if (content_reg != 16'd0)
                        phase_next = fcgi_rhp_pkg::PH_CONTENT;
                    else if (pad_reg != 8'd0)
                        phase_next = fcgi_rhp_pkg::PH_PADDING;
                end
            end
        endcase

        // record end; END and ABORT records are reported and reset the parser
        if ((phase_reg == fcgi_rhp_pkg::PH_CONTENT && content_next == 16'd0
             && pad_reg == 8'd0)
            || (phase_reg == fcgi_rhp_pkg::PH_PADDING && pad_next == 8'd0)
            || (phase_reg != fcgi_rhp_pkg::PH_CONTENT && phase_reg != fcgi_rhp_pkg::PH_PADDING
                && hidx_reg == fcgi_rhp_pkg::HDR_LAST && content_reg == 16'd0
                && pad_reg == 8'd0))
        begin
            phase_next = fcgi_rhp_pkg::PH_HEADER;
            hidx_next  = 3'd0;
            if (kind_reg == fcgi_rhp_pkg::REC_END || kind_reg == fcgi_rhp_pkg::REC_ABORT)
            begin
                ev = fcgi_rhp_pkg::add_event(ev,
                    (kind_reg == fcgi_rhp_pkg::REC_END)
                        ? fcgi_rhp_pkg::KIND_DONE : fcgi_rhp_pkg::KIND_ABORTED, 8'h00);
                line_next    = fcgi_rhp_pkg::LS_START;
                kind_next    = 8'd0;
                len_hi_next  = 8'd0;
                content_next = 16'd0;
                pad_next     = 8'd0;
                body_next    = 1'b0;
            end
        end

        ev.r0.last = (ev.count == 2'd1);
        ev.r1.last = 1'b1;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= fcgi_rhp_pkg::PH_HEADER;
            line_reg    <= fcgi_rhp_pkg::LS_START;
            hidx_reg    <= 3'd0;
            kind_reg    <= 8'd0;
            len_hi_reg  <= 8'd0;
            content_reg <= 16'd0;
            pad_reg     <= 8'd0;
            body_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            line_reg    <= line_next;
            hidx_reg    <= hidx_next;
            kind_reg    <= kind_next;
            len_hi_reg  <= len_hi_next;
            content_reg <= content_next;
            pad_reg     <= pad_next;
            body_reg    <= body_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (accept && ev.count != 2'd0)
            queue_mem[tail_reg] <= ev.r0;
        if (accept && ev.count == 2'd2)
            queue_mem[tail_reg + 2'd1] <= ev.r1;
    end

    assign count_next = count_reg + {1'b0, (accept ? ev.count : 2'd0)} - {2'b00, pop};

    // result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (accept)
                tail_reg <= tail_reg + (accept ? ev.count : 2'd0);
            if (pop)
                head_reg <= head_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    assign head_res     = queue_mem[head_reg];
    assign m_axis_tdata = head_res.data;
    assign m_axis_tuser = head_res.kind;
    assign m_axis_tlast = head_res.last;

`ifndef NO_ASSERTIONS
    // queue never overflows
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    // content phase always has bytes left
    a_content_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == fcgi_rhp_pkg::PH_CONTENT |-> content_reg != 16'd0)
        else $error("content phase with no content left");

    // padding phase always has bytes left
    a_padding_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == fcgi_rhp_pkg::PH_PADDING |-> pad_reg != 8'd0)
        else $error("padding phase with no padding left");

    // done or aborted returns the parser to its reset state
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ev.count != 2'd0
        && (ev.r0.kind == fcgi_rhp_pkg::KIND_DONE || ev.r0.kind == fcgi_rhp_pkg::KIND_ABORTED)
        |=> phase_reg == fcgi_rhp_pkg::PH_HEADER && hidx_reg == 3'd0 && !body_reg
            && line_reg == fcgi_rhp_pkg::LS_START)
        else $error("parser not reset after end of request");
`endif

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for fastcgi_response_header_parser
// Streams FastCGI response records into the parser and checks every event
// against a cycle-free model of the deframer and CGI header-line parser.
// A short directed sequence is followed by random responses, record noise and
// cut-off responses, under three source/sink pacing phases and one long sink
// hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    typedef enum int { PACE_SINK_IDLES, PACE_SOURCE_IDLES, PACE_FREE } pace_t;

    localparam int unsigned ITEMS_PER_PHASE = 520;
    localparam int unsigned LONG_HOLD       = 400;
    localparam int unsigned IDLE_LIMIT      = 4000;
    localparam int unsigned TAIL_CYCLES     = 20;
    localparam logic [7:0]  REC_STDERR      = 8'd7;

    logic       clk;
    logic       rst_n;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data  = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    // stimulus and scoreboard storage
    logic [7:0]            byte_stream[$];
    logic [7:0]            cgi_text[$];
    fcgi_rhp_pkg::result_t step_events[$];
    fcgi_rhp_pkg::result_t expected_events[$];
    pace_t       pace_mode   = PACE_SINK_IDLES;
    bit          hold_armed  = 1'b0;
    int unsigned hold_count  = 0;
    int unsigned bytes_queued = 0;
    int unsigned bytes_in    = 0;
    int unsigned events_out  = 0;
    int unsigned done_seen   = 0;
    int unsigned aborted_seen = 0;
    int unsigned err_count   = 0;
    int unsigned idle_cycles = 0;

    // parser model state
    fcgi_rhp_pkg::phase_t      rx_phase;
    logic [2:0]                hdr_pos;
    logic [7:0]                rec_type;
    logic [7:0]                len_hi;
    logic [15:0]               content_left;
    logic [7:0]                pad_left;
    fcgi_rhp_pkg::line_state_t line_st;
    bit                        in_body;

    fastcgi_response_header_parser uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    task automatic reset_parser();
        rx_phase     = fcgi_rhp_pkg::PH_HEADER;
        hdr_pos      = 3'd0;
        rec_type     = 8'd0;
        len_hi       = 8'd0;
        content_left = 16'd0;
        pad_left     = 8'd0;
        line_st      = fcgi_rhp_pkg::LS_START;
        in_body      = 1'b0;
    endtask

    // at most two events per stream byte
    task automatic note_event(input logic [2:0] kind, input logic [7:0] data);
        fcgi_rhp_pkg::result_t e;
        if (step_events.size() < 2)
        begin
            e.kind = kind;
            e.data = data;
            e.last = 1'b0;
            step_events.push_back(e);
        end
    endtask

    // first byte of a header line
    task automatic start_line(input logic [7:0] b);
        if (b == fcgi_rhp_pkg::CH_CR)
        begin
            note_event(fcgi_rhp_pkg::KIND_HEADERS_END, 8'h00);
            in_body = 1'b1;
            line_st = fcgi_rhp_pkg::LS_BLANK_CR;
        end
        else if (b == fcgi_rhp_pkg::CH_LF)
        begin
            note_event(fcgi_rhp_pkg::KIND_HEADERS_END, 8'h00);
            in_body = 1'b1;
            line_st = fcgi_rhp_pkg::LS_START;
        end
        else if (b == fcgi_rhp_pkg::CH_COLON)
            line_st = fcgi_rhp_pkg::LS_SKIP;
        else
        begin
            note_event(fcgi_rhp_pkg::KIND_NAME, b);
            line_st = fcgi_rhp_pkg::LS_NAME;
        end
    endtask

    task automatic take_value_char(input logic [7:0] b);
        if (b == fcgi_rhp_pkg::CH_CR)
            line_st = fcgi_rhp_pkg::LS_CR;
        else if (b == fcgi_rhp_pkg::CH_LF)
            line_st = fcgi_rhp_pkg::LS_LF;
        else
        begin
            note_event(fcgi_rhp_pkg::KIND_VALUE, b);
            line_st = fcgi_rhp_pkg::LS_VALUE;
        end
    endtask

    // end of a record: request end and abort reset the parser
    task automatic close_record();
        if (rec_type == fcgi_rhp_pkg::REC_END)
        begin
            note_event(fcgi_rhp_pkg::KIND_DONE, 8'h00);
            reset_parser();
        end
        else if (rec_type == fcgi_rhp_pkg::REC_ABORT)
        begin
            note_event(fcgi_rhp_pkg::KIND_ABORTED, 8'h00);
            reset_parser();
        end
        else
        begin
            rx_phase = fcgi_rhp_pkg::PH_HEADER;
            hdr_pos  = 3'd0;
        end
    endtask

    // one stream byte in, its events appended to the expected list
    task automatic parse_stream_byte(input logic [7:0] b);
        fcgi_rhp_pkg::result_t e;
        bit      blank;
        int      i;
        step_events.delete();
        blank = (b == fcgi_rhp_pkg::CH_SPACE) || (b == fcgi_rhp_pkg::CH_TAB);
        case (rx_phase)
            fcgi_rhp_pkg::PH_CONTENT:
            begin
                content_left = content_left - 16'd1;
                if (rec_type == fcgi_rhp_pkg::REC_STDOUT)
                begin
                    if (in_body)
                    begin
                        if (!(line_st == fcgi_rhp_pkg::LS_BLANK_CR
                              && b == fcgi_rhp_pkg::CH_LF))
                            note_event(fcgi_rhp_pkg::KIND_BODY, b);
                        line_st = fcgi_rhp_pkg::LS_START;
                    end
                    else
                    begin
                        case (line_st)
                            fcgi_rhp_pkg::LS_NAME:
                            begin
                                if (b == fcgi_rhp_pkg::CH_COLON)
                                    line_st = fcgi_rhp_pkg::LS_SKIP;
                                else if (b == fcgi_rhp_pkg::CH_CR)
                                    line_st = fcgi_rhp_pkg::LS_CR;
                                else if (b == fcgi_rhp_pkg::CH_LF)
                                    line_st = fcgi_rhp_pkg::LS_LF;
                                else
                                    note_event(fcgi_rhp_pkg::KIND_NAME, b);
                            end
                            fcgi_rhp_pkg::LS_SKIP:
                            begin
                                if (!blank)
                                    take_value_char(b);
                            end
                            fcgi_rhp_pkg::LS_VALUE:
                                take_value_char(b);
                            fcgi_rhp_pkg::LS_CR:
                            begin
                                if (b == fcgi_rhp_pkg::CH_LF)
                                    line_st = fcgi_rhp_pkg::LS_LF;
                                else if (blank)
                                    line_st = fcgi_rhp_pkg::LS_SKIP;
                                else
                                begin
                                    note_event(fcgi_rhp_pkg::KIND_LINE_END, 8'h00);
                                    start_line(b);
                                end
                            end
                            fcgi_rhp_pkg::LS_LF:
                            begin
                                if (blank)
                                    line_st = fcgi_rhp_pkg::LS_SKIP;
                                else
                                begin
                                    note_event(fcgi_rhp_pkg::KIND_LINE_END, 8'h00);
                                    start_line(b);
                                end
                            end
                            default:
                                start_line(b);
                        endcase
                    end
                end
                if (content_left == 16'd0)
                begin
                    if (pad_left != 8'd0)
                        rx_phase = fcgi_rhp_pkg::PH_PADDING;
                    else
                        close_record();
                end
            end
            fcgi_rhp_pkg::PH_PADDING:
            begin
                pad_left = pad_left - 8'd1;
                if (pad_left == 8'd0)
                    close_record();
            end
            default:
            begin
                rx_phase = fcgi_rhp_pkg::PH_HEADER;
                case (hdr_pos)
                    fcgi_rhp_pkg::HDR_TYPE:    rec_type = b;
                    fcgi_rhp_pkg::HDR_LEN_HI:  len_hi = b;
                    fcgi_rhp_pkg::HDR_LEN_LO:  content_left = {len_hi, b};
                    fcgi_rhp_pkg::HDR_PADDING: pad_left = b;
                    default:                   ;
                endcase
                if (hdr_pos == fcgi_rhp_pkg::HDR_LAST)
                begin
                    hdr_pos = 3'd0;
                    if (content_left != 16'd0)
                        rx_phase = fcgi_rhp_pkg::PH_CONTENT;
                    else if (pad_left != 8'd0)
                        rx_phase = fcgi_rhp_pkg::PH_PADDING;
                    else
                        close_record();
                end
                else
                    hdr_pos = hdr_pos + 3'd1;
            end
        endcase
        for (i = 0; i < step_events.size(); i++)
        begin
            e = step_events[i];
            e.last = (i == step_events.size() - 1);
            expected_events.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b);
        byte_stream.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [7:0] any_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return c;
    endfunction

    // mostly letters, sometimes any byte at all
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(7) == 0)
            c = 8'($urandom_range(255));
        else
            c = 8'(8'h61 + $urandom_range(25));
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(1) ? fcgi_rhp_pkg::CH_SPACE : fcgi_rhp_pkg::CH_TAB;
    endfunction

    // record header with random version, request id and reserved bytes
    task automatic put_header(input logic [7:0] kind, input logic [15:0] len,
                              input logic [7:0] pad);
        put_byte(any_byte());
        put_byte(kind);
        put_byte(any_byte());
        put_byte(any_byte());
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        put_byte(pad);
        put_byte(any_byte());
    endtask

    task automatic put_padding(input int unsigned pad);
        int unsigned k;
        for (k = 0; k < pad; k++)
            put_byte(any_byte());
    endtask

    task automatic put_opaque_record(input logic [7:0] kind, input int unsigned len,
                                     input int unsigned pad);
        put_header(kind, len[15:0], pad[7:0]);
        put_padding(len);
        put_padding(pad);
    endtask

    task automatic put_line_end();
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6)
        begin
            cgi_text.push_back(fcgi_rhp_pkg::CH_CR);
            cgi_text.push_back(fcgi_rhp_pkg::CH_LF);
        end
        else if (r < 8)
            cgi_text.push_back(fcgi_rhp_pkg::CH_LF);
        else
            cgi_text.push_back(fcgi_rhp_pkg::CH_CR);
    endtask

    // header lines, usually a blank line, then some body
    task automatic build_response_text();
        int unsigned lines, i, k, form;
        cgi_text.delete();
        lines = $urandom_range(4);
        for (i = 0; i < lines; i++)
        begin
            form = $urandom_range(9);
            if (form != 0)
                for (k = $urandom_range(1, 6); k > 0; k--)
                    cgi_text.push_back(text_char());
            if (form != 1)
            begin
                cgi_text.push_back(fcgi_rhp_pkg::CH_COLON);
                for (k = $urandom_range(2); k > 0; k--)
                    cgi_text.push_back(blank_char());
                for (k = $urandom_range(6); k > 0; k--)
                    cgi_text.push_back(text_char());
                // folded continuation
                if ($urandom_range(4) == 0)
                begin
                    put_line_end();
                    for (k = $urandom_range(1, 2); k > 0; k--)
                        cgi_text.push_back(blank_char());
                    for (k = $urandom_range(1, 4); k > 0; k--)
                        cgi_text.push_back(text_char());
                end
            end
            put_line_end();
        end
        if ($urandom_range(6) != 0)
        begin
            put_line_end();
            for (k = $urandom_range(10); k > 0; k--)
                cgi_text.push_back(any_byte());
        end
    endtask

    // split text over stdout records with stray other records in between
    task automatic put_stdout_text(input int unsigned keep);
        int unsigned idx, n, pad, k;
        idx = 0;
        while (idx < keep)
        begin
            n = $urandom_range(1, 24);
            if (n > keep - idx)
                n = keep - idx;
            pad = $urandom_range(1) ? 0 : $urandom_range(1, 7);
            put_header(fcgi_rhp_pkg::REC_STDOUT, n[15:0], pad[7:0]);
            for (k = 0; k < n; k++)
                put_byte(cgi_text[idx + k]);
            idx += n;
            put_padding(pad);
            if ($urandom_range(7) == 0)
                put_opaque_record(REC_STDERR, $urandom_range(12), $urandom_range(3));
            if ($urandom_range(15) == 0)
                put_opaque_record(fcgi_rhp_pkg::REC_STDOUT, 0, $urandom_range(2));
        end
    endtask

    // one response: text records, then an end or abort record
    task automatic put_response();
        int unsigned keep, r;
        build_response_text();
        keep = cgi_text.size();
        if ($urandom_range(4) == 0)
            keep = $urandom_range(keep);
        put_stdout_text(keep);
        r = $urandom_range(19);
        if (r < 14)
            put_opaque_record(fcgi_rhp_pkg::REC_END, 8, 0);
        else if (r < 17)
            put_opaque_record(fcgi_rhp_pkg::REC_ABORT, $urandom_range(8),
                              $urandom_range(2));
        else
            put_opaque_record(fcgi_rhp_pkg::REC_END, 0, 0);
    endtask

    // random responses plus some record noise
    task automatic put_random_phase();
        int unsigned start;
        start = bytes_queued;
        while (bytes_queued - start < ITEMS_PER_PHASE)
        begin
            if ($urandom_range(9) == 0)
                put_opaque_record(any_byte(), $urandom_range(16), $urandom_range(3));
            else
                put_response();
        end
    endtask

    task automatic put_directed();
        // empty name, skipped blank, fold, bare lf, line without colon,
        // blank line ending on cr with its lf in the next record
        put_header(fcgi_rhp_pkg::REC_STDOUT, 16'd11, 8'd1);
        put_byte(fcgi_rhp_pkg::CH_COLON);
        put_byte(fcgi_rhp_pkg::CH_SPACE);
        put_byte(8'h76);
        put_byte(fcgi_rhp_pkg::CH_CR);
        put_byte(fcgi_rhp_pkg::CH_TAB);
        put_byte(8'h77);
        put_byte(fcgi_rhp_pkg::CH_LF);
        put_byte(8'h4E);
        put_byte(fcgi_rhp_pkg::CH_CR);
        put_byte(fcgi_rhp_pkg::CH_LF);
        put_byte(fcgi_rhp_pkg::CH_CR);
        put_byte(8'h00);
        put_header(fcgi_rhp_pkg::REC_STDOUT, 16'd2, 8'd0);
        put_byte(fcgi_rhp_pkg::CH_LF);
        put_byte(8'hFF);
        // empty end-of-request record
        put_header(fcgi_rhp_pkg::REC_END, 16'd0, 8'd0);
    endtask

    // wait until the source is empty and every expected event has arrived
    task automatic wait_drained();
        while (byte_stream.size() != 0 || s_valid || expected_events.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued stream bytes
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : driver_proc
        bit gap;
        if (!rst_n)
            s_valid <= 1'b0;
        else if (!s_valid || s_ready)
        begin
            case (pace_mode)
                PACE_SINK_IDLES:   gap = ($urandom_range(99) < 10);
                PACE_SOURCE_IDLES: gap = ($urandom_range(99) < 62);
                default:           gap = 1'b0;
            endcase
            if (byte_stream.size() != 0 && !gap)
            begin
                s_valid <= 1'b1;
                s_data  <= byte_stream.pop_front();
            end
            else
                s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on each accepted request, checks each event
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor_proc
        fcgi_rhp_pkg::result_t want;
        bit      gap;
        if (!rst_n)
        begin
            reset_parser();
            m_ready <= 1'b0;
        end
        else
        begin
            if (s_valid && s_ready)
            begin
                parse_stream_byte(s_data);
                bytes_in++;
            end
            if (m_valid && m_ready)
            begin
                events_out++;
                if (m_tuser == fcgi_rhp_pkg::KIND_DONE)
                    done_seen++;
                if (m_tuser == fcgi_rhp_pkg::KIND_ABORTED)
                    aborted_seen++;
                if (expected_events.size() == 0)
                begin
                    $error("unexpected event: event_kind %0d event_byte 0x%02h",
                           m_tuser, m_tdata);
                    err_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("event_kind mismatch: expected %0d, got %0d",
                               want.kind, m_tuser);
                        err_count++;
                    end
                    if (m_tdata !== want.data)
                    begin
                        $error("event_byte mismatch: expected 0x%02h, got 0x%02h",
                               want.data, m_tdata);
                        err_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_run mismatch: expected %0d, got %0d",
                               want.last, m_tlast);
                        err_count++;
                    end
                end
            end
            // sink pacing, with one long hold-off
            if (hold_armed && hold_count < LONG_HOLD)
            begin
                hold_count <= hold_count + 1;
                m_ready    <= 1'b0;
            end
            else
            begin
                case (pace_mode)
                    PACE_SINK_IDLES:   gap = ($urandom_range(99) < 62);
                    PACE_SOURCE_IDLES: gap = ($urandom_range(99) < 10);
                    default:           gap = 1'b0;
                endcase
                m_ready <= !gap;
            end
        end
    end

    // watchdog on cycles without any request or event moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // reset and test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed records and first random batch, sink held off early
        put_directed();
        put_random_phase();
        hold_armed = 1'b1;
        wait_drained();

        // source idles more than the sink
        pace_mode = PACE_SOURCE_IDLES;
        put_random_phase();
        wait_drained();

        // no idling, plus one long skipped record with a nonzero length high byte
        pace_mode = PACE_FREE;
        put_opaque_record(8'hFF, 260, 16);
        put_random_phase();
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        $display("tb_top: %0d stream bytes in, %0d events checked", bytes_in, events_out);
        $display("tb_top: %0d responses completed, %0d aborted, over three pacing phases",
                 done_seen, aborted_seen);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/fcgi_rhp_pkg.sv
hdl/fastcgi_response_header_parser.sv
verif/tb_top.sv
